>>> rtl/core/directional_nearest_rect_select_assert.svh
// Assertion macros used by the selector top level.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message.
`ifndef DIRECTIONAL_NEAREST_RECT_SELECT_ASSERT_SVH
`define DIRECTIONAL_NEAREST_RECT_SELECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNRS_CHECK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DNRS_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dnrs_pkg.sv
`timescale 1ns / 1ps

package dnrs_pkg;

    localparam int REG_BITS      = 16;
    localparam int DIST_BITS     = 18;
    localparam int OP_BITS       = 2;
    localparam int DIR_BITS      = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int NUM_VALS      = 8;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [DIST_BITS-1:0] DIST_NONE = '1;

    // Request operation codes.
    localparam logic [OP_BITS-1:0] OP_START  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CAND   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FINISH = 2'd2;

    // Search directions.
    localparam logic [DIR_BITS-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_RIGHT = 2'd2;
    localparam logic [DIR_BITS-1:0] DIR_LEFT  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_SCAN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCAN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRACE_UP    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRACE_DOWN  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRACE_RIGHT = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRACE_LEFT  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CROSS_WS    = 3'd6;

    // Slots of the value array in a queue entry. A start entry carries the
    // reference centre and band halves; a candidate entry carries its edges
    // and one distance key per direction.
    localparam int V_CX        = 0;
    localparam int V_CY        = 1;
    localparam int V_HALF_W    = 2;
    localparam int V_HALF_H    = 3;
    localparam int V_LEFT      = 0;
    localparam int V_RIGHT     = 1;
    localparam int V_TOP       = 2;
    localparam int V_BOTTOM    = 3;
    localparam int V_KEY_UP    = 4;
    localparam int V_KEY_DOWN  = 5;
    localparam int V_KEY_RIGHT = 6;
    localparam int V_KEY_LEFT  = 7;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_CAND,
        KIND_FINISH
    } kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> rtl/core/dnrs_fifo.sv
`timescale 1ns / 1ps

module dnrs_fifo
    import dnrs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output fifo_status_t     status
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign rdata        = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/core/dnrs_front.sv
`timescale 1ns / 1ps

module dnrs_front
    import dnrs_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int COORD_BITS = 16,
    parameter int AW         = 20,
    parameter int IN_W       = 112,
    parameter int ENTRY_W    = 181
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [OP_BITS-1:0]      s_tuser,
    input  logic [IN_W-1:0]         s_tdata,
    input  fifo_status_t            q_status,
    output logic                    q_push,
    output logic [ENTRY_W-1:0]      q_wdata
);

    localparam int O_DIR  = 0;
    localparam int O_X    = O_DIR + DIR_BITS;
    localparam int O_Y    = O_X + COORD_BITS;
    localparam int O_W    = O_Y + COORD_BITS;
    localparam int O_H    = O_W + COORD_BITS - 1;
    localparam int O_AW   = O_H + COORD_BITS - 1;
    localparam int O_AH   = O_AW + COORD_BITS - 1;
    localparam int O_ID   = O_AH + COORD_BITS - 1;
    localparam int O_SKIP = O_ID + ID_BITS;

    typedef struct packed {
        kind_t                         kind;
        logic [DIR_BITS-1:0]           dir;
        logic                          eligible;
        logic [ID_BITS-1:0]            id;
        logic [NUM_VALS-1:0][AW-1:0]   val;
    } entry_t;

    logic [REG_BITS-1:0] scan_w_reg;
    logic [REG_BITS-1:0] scan_h_reg;
    logic [REG_BITS-1:0] grace_up_reg;
    logic [REG_BITS-1:0] grace_down_reg;
    logic [REG_BITS-1:0] grace_right_reg;
    logic [REG_BITS-1:0] grace_left_reg;
    logic                cross_ws_reg;

    logic signed [AW-1:0] x_s;
    logic signed [AW-1:0] y_s;
    logic signed [AW-1:0] w_s;
    logic signed [AW-1:0] h_s;
    logic signed [AW-1:0] aw_s;
    logic signed [AW-1:0] ah_s;
    logic signed [AW-1:0] hw_s;
    logic signed [AW-1:0] hh_s;
    logic signed [AW-1:0] cx_s;
    logic signed [AW-1:0] cy_s;
    logic                 visible;
    logic                 known_op;
    entry_t               ent;

    function automatic logic signed [AW-1:0] ext_reg(input logic [REG_BITS-1:0] v);
        return {{(AW-REG_BITS){v[REG_BITS-1]}}, v};
    endfunction

    function automatic logic signed [AW-1:0] ext_size(input logic [COORD_BITS-2:0] v);
        return {{(AW-COORD_BITS+1){1'b0}}, v};
    endfunction

    // Half of the scan band on one axis, truncated and raised to at least one.
    function automatic logic signed [AW-1:0] band_half(
        input logic signed [AW-1:0] scan,
        input logic signed [AW-1:0] size
    );
        logic signed [AW-1:0] full;
        if (scan > 0)
            full = scan;
        else if (scan < 0)
            full = size + scan;
        else
            full = size;
        if (full < 2)
            return AW'(1);
        return full >>> 1;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_w_reg      <= '0;
            scan_h_reg      <= '0;
            grace_up_reg    <= '0;
            grace_down_reg  <= '0;
            grace_right_reg <= '0;
            grace_left_reg  <= '0;
            cross_ws_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCAN_WIDTH:  scan_w_reg      <= cfg_data;
                REG_SCAN_HEIGHT: scan_h_reg      <= cfg_data;
                REG_GRACE_UP:    grace_up_reg    <= cfg_data;
                REG_GRACE_DOWN:  grace_down_reg  <= cfg_data;
                REG_GRACE_RIGHT: grace_right_reg <= cfg_data;
                REG_GRACE_LEFT:  grace_left_reg  <= cfg_data;
                REG_CROSS_WS:    cross_ws_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        x_s  = {{(AW-COORD_BITS){s_tdata[O_X+COORD_BITS-1]}}, s_tdata[O_X +: COORD_BITS]};
        y_s  = {{(AW-COORD_BITS){s_tdata[O_Y+COORD_BITS-1]}}, s_tdata[O_Y +: COORD_BITS]};
        w_s  = ext_size(s_tdata[O_W +: COORD_BITS-1]);
        h_s  = ext_size(s_tdata[O_H +: COORD_BITS-1]);
        aw_s = ext_size(s_tdata[O_AW +: COORD_BITS-1]);
        ah_s = ext_size(s_tdata[O_AH +: COORD_BITS-1]);
        hw_s = w_s >>> 1;
        hh_s = h_s >>> 1;
        cx_s = x_s + hw_s;
        cy_s = y_s + hh_s;

        visible = !s_tdata[O_SKIP] &&
                  (cross_ws_reg ||
                   (cx_s >= 0 && cx_s < aw_s && cy_s >= 0 && cy_s < ah_s));

        ent          = '0;
        ent.dir      = s_tdata[O_DIR +: DIR_BITS];
        ent.id       = s_tdata[O_ID +: ID_BITS];
        ent.eligible = visible;
        known_op     = 1'b1;

        case (s_tuser)
            OP_START:
            begin
                ent.kind           = KIND_START;
                ent.val[V_CX]      = cx_s;
                ent.val[V_CY]      = cy_s;
                ent.val[V_HALF_W]  = band_half(ext_reg(scan_w_reg), w_s);
                ent.val[V_HALF_H]  = band_half(ext_reg(scan_h_reg), h_s);
            end
            OP_CAND:
            begin
                // Each key is arranged so that the back end needs one subtract
                // against the reference centre for the selected direction.
                ent.kind             = KIND_CAND;
                ent.val[V_LEFT]      = cx_s - hw_s;
                ent.val[V_RIGHT]     = cx_s + hw_s;
                ent.val[V_TOP]       = cy_s - hh_s;
                ent.val[V_BOTTOM]    = cy_s + hh_s;
                ent.val[V_KEY_UP]    = cy_s + ext_reg(grace_up_reg);
                ent.val[V_KEY_DOWN]  = cy_s - ext_reg(grace_down_reg);
                ent.val[V_KEY_RIGHT] = cx_s - ext_reg(grace_right_reg);
                ent.val[V_KEY_LEFT]  = cx_s + ext_reg(grace_left_reg);
            end
            OP_FINISH:
            begin
                ent.kind = KIND_FINISH;
            end
            default:
            begin
                ent.kind = KIND_FINISH;
                known_op = 1'b0;
            end
        endcase
    end

    // An unused operation code is accepted and dropped here.
    assign q_push  = s_tvalid && s_tready && known_op;
    assign q_wdata = ent;

endmodule

>>> rtl/core/dnrs_back.sv
`timescale 1ns / 1ps

module dnrs_back
    import dnrs_pkg::*;
#(
    parameter int ID_BITS = 16,
    parameter int AW      = 20,
    parameter int ENTRY_W = 181,
    parameter int OUT_W   = 40
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  fifo_status_t       q_status,
    input  logic [ENTRY_W-1:0] q_rdata,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata
);

    typedef struct packed {
        kind_t                         kind;
        logic [DIR_BITS-1:0]           dir;
        logic                          eligible;
        logic [ID_BITS-1:0]            id;
        logic [NUM_VALS-1:0][AW-1:0]   val;
    } entry_t;

    entry_t               head;
    logic                 out_free;
    logic                 in_band;
    logic signed [AW-1:0] cand_dist;
    logic signed [AW-1:0] best_ext;
    logic                 win;

    logic signed [AW-1:0] ref_x_reg;
    logic signed [AW-1:0] ref_y_reg;
    logic signed [AW-1:0] lo_x_reg;
    logic signed [AW-1:0] hi_x_reg;
    logic signed [AW-1:0] lo_y_reg;
    logic signed [AW-1:0] hi_y_reg;
    logic [DIR_BITS-1:0]  dir_reg;
    logic [DIST_BITS-1:0] best_dist_reg;
    logic [ID_BITS-1:0]   best_id_reg;
    logic                 have_best_reg;
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    assign head     = entry_t'(q_rdata);
    assign out_free = !m_tvalid_reg || m_tready;
    // A finish waits only while the output register holds an untaken report.
    assign q_pop    = !q_status.empty && ((head.kind != KIND_FINISH) || out_free);
    assign best_ext = $signed({{(AW-DIST_BITS){1'b0}}, best_dist_reg});

    always_comb
    begin
        case (dir_reg)
            DIR_UP:
            begin
                in_band   = ($signed(head.val[V_RIGHT]) >= lo_x_reg) &&
                            ($signed(head.val[V_LEFT]) <= hi_x_reg);
                cand_dist = ref_y_reg - $signed(head.val[V_KEY_UP]);
            end
            DIR_DOWN:
            begin
                in_band   = ($signed(head.val[V_RIGHT]) >= lo_x_reg) &&
                            ($signed(head.val[V_LEFT]) <= hi_x_reg);
                cand_dist = $signed(head.val[V_KEY_DOWN]) - ref_y_reg;
            end
            DIR_RIGHT:
            begin
                in_band   = ($signed(head.val[V_BOTTOM]) >= lo_y_reg) &&
                            ($signed(head.val[V_TOP]) <= hi_y_reg);
                cand_dist = $signed(head.val[V_KEY_RIGHT]) - ref_x_reg;
            end
            default:
            begin
                in_band   = ($signed(head.val[V_BOTTOM]) >= lo_y_reg) &&
                            ($signed(head.val[V_TOP]) <= hi_y_reg);
                cand_dist = ref_x_reg - $signed(head.val[V_KEY_LEFT]);
            end
        endcase
        // Strictly below keeps the earlier of two equal candidates.
        win = head.eligible && in_band && !cand_dist[AW-1] && (cand_dist < best_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            lo_x_reg      <= -AW'(1);
            hi_x_reg      <= AW'(1);
            lo_y_reg      <= -AW'(1);
            hi_y_reg      <= AW'(1);
            dir_reg       <= DIR_UP;
            best_dist_reg <= DIST_NONE;
            best_id_reg   <= '0;
            have_best_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                case (head.kind)
                    KIND_START:
                    begin
                        ref_x_reg     <= $signed(head.val[V_CX]);
                        ref_y_reg     <= $signed(head.val[V_CY]);
                        lo_x_reg      <= $signed(head.val[V_CX]) - $signed(head.val[V_HALF_W]);
                        hi_x_reg      <= $signed(head.val[V_CX]) + $signed(head.val[V_HALF_W]);
                        lo_y_reg      <= $signed(head.val[V_CY]) - $signed(head.val[V_HALF_H]);
                        hi_y_reg      <= $signed(head.val[V_CY]) + $signed(head.val[V_HALF_H]);
                        dir_reg       <= head.dir;
                        best_dist_reg <= DIST_NONE;
                        best_id_reg   <= '0;
                        have_best_reg <= 1'b0;
                    end
                    KIND_CAND:
                    begin
                        if (win)
                        begin
                            best_dist_reg <= cand_dist[DIST_BITS-1:0];
                            best_id_reg   <= head.id;
                            have_best_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (q_pop && (head.kind == KIND_FINISH))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (head.kind == KIND_FINISH))
        begin
            m_tdata_reg <= OUT_W'({best_dist_reg, best_id_reg, have_best_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/core/directional_nearest_rect_select.sv
// Nearest rectangle search in one direction.
// Requests arrive on the s_ stream: tuser carries the operation (start,
// candidate, finish) and tdata the rectangle, area, identifier and skip flag.
// A start request sets the reference centre, scan band and direction and
// clears the running best; a candidate request may replace the best; a finish
// request returns one report on the m_ stream and leaves the best untouched.
// Unused operation codes are accepted and dropped.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// they are always taken and must be made while no request is in flight.
// Throughput is one request per cycle while the queue has room. A request
// passes a four-entry queue from the classifying front end to the selecting
// back end, and a finish leaves it for the output register behind m_tvalid.
// When the receiver holds m_tready low, the report waits in the output
// register, later finish requests wait at the queue head, and s_tready falls
// once the queue is full. Start and candidate requests ahead of them drain.
// Reset clears the configuration to zero, the band halves to one, the
// reference to the origin, and the best to none.
`timescale 1ns / 1ps
`include "directional_nearest_rect_select_assert.svh"

module directional_nearest_rect_select
    import dnrs_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // tuser: operation
    input  logic [OP_BITS-1:0]      s_tuser,
    // tdata: direction, rect_x, rect_y, rect_w, rect_h, area_w, area_h,
    //        candidate_id, skip, zero padding
    input  logic [((6*COORD_BITS+ID_BITS+6)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // tdata: found, best_id, best_distance, zero padding
    output logic [((ID_BITS+DIST_BITS+8)/8)*8-1:0]    m_tdata
);

    localparam int AW      = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 4;
    localparam int IN_W    = ((6*COORD_BITS + ID_BITS + 6) / 8) * 8;
    localparam int OUT_W   = ((ID_BITS + DIST_BITS + 8) / 8) * 8;
    localparam int ENTRY_W = 2 + DIR_BITS + 1 + ID_BITS + NUM_VALS*AW;
    localparam int DIST_LO = ID_BITS + 1;
    localparam int DIST_HI = ID_BITS + DIST_BITS;

    fifo_status_t       q_status;
    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    dnrs_front #(
        .ID_BITS    (ID_BITS),
        .COORD_BITS (COORD_BITS),
        .AW         (AW),
        .IN_W       (IN_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    dnrs_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    dnrs_back #(
        .ID_BITS (ID_BITS),
        .AW      (AW),
        .ENTRY_W (ENTRY_W),
        .OUT_W   (OUT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A report without a winner carries the empty identifier and distance.
    `DNRS_CHECK_NOW(a_none_report, clk, rst_n, m_tvalid && !m_tdata[0], (m_tdata[ID_BITS:1] == '0) && (m_tdata[DIST_HI:DIST_LO] == DIST_NONE), "report without winner has stale fields")
    // A winner always has a distance below the empty marker.
    `DNRS_CHECK_NOW(a_found_dist, clk, rst_n, m_tvalid && m_tdata[0], m_tdata[DIST_HI:DIST_LO] != DIST_NONE, "winner reported with empty distance")
    // The back end cannot take an entry that was never written.
    `DNRS_CHECK_NEXT(a_no_phantom_pop, clk, rst_n, q_status.empty && !q_push, !q_pop, "queue popped while empty")

endmodule
